// File: hdl/utility_per_cost_selector_defines.svh
// ----------------------------------------------------------------------------
// Utility-per-cost selector assertion macros
// Shared property forms for the selector's concurrent checks.
// ----------------------------------------------------------------------------
`ifndef UTILITY_PER_COST_SELECTOR_DEFINES_SVH
`define UTILITY_PER_COST_SELECTOR_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define UPCS_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("upcs check failed in %m");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define UPCS_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("upcs check failed in %m");

`endif

// File: hdl/upcs_pkg.sv
// ----------------------------------------------------------------------------
// upcs_pkg
// Types and constants shared by the utility-per-cost selector modules.
// ----------------------------------------------------------------------------
package upcs_pkg;

    localparam int SLOTS  = 8;
    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    localparam int UTIL_W     = 16;
    localparam int TICK_W     = 32;
    localparam int COST_W     = 32;
    localparam int FLAGS_W    = 8;
    localparam int TID_W      = 3;
    localparam int CNT_W      = 4;
    localparam int CURSOR_W   = 8;
    localparam int MASK_W     = 8;
    localparam int MASK_IDX_W = 3;
    localparam int CHOSEN_W   = 3;
    localparam int SCORE_W    = 32;

    localparam int SCORE_SHIFT       = 16;
    localparam int FLAG_DEADLINE_BIT = 0;

    // shared divider: (utility << 16) / cost
    localparam int DVD_W      = UTIL_W + SCORE_SHIFT;
    localparam int DVS_W      = COST_W;
    localparam int DIV_STEP_W = $clog2(DVD_W);

    localparam int IN_DATA_W  = 144;
    localparam int OUT_DATA_W = 128;

    typedef enum logic [1:0] {
        MODE_SET    = 2'd0,
        MODE_CLEAR  = 2'd1,
        MODE_GET    = 2'd2,
        MODE_SELECT = 2'd3
    } mode_t;

    typedef struct packed {
        logic [UTIL_W-1:0]  utility;
        logic [TICK_W-1:0]  deadline;
        logic [COST_W-1:0]  cost;
        logic [FLAGS_W-1:0] flags;
    } hint_t;

    typedef struct packed {
        logic              wr;
        logic              clr;
        logic              rd;
        logic [SLOT_W-1:0] addr;
        hint_t             data;
    } tbl_cmd_t;

    typedef struct packed {
        logic  valid;
        hint_t hint;
    } tbl_rsp_t;

    typedef struct packed {
        logic             start;
        logic [DVD_W-1:0] dividend;
        logic [DVS_W-1:0] divisor;
    } div_cmd_t;

    typedef struct packed {
        logic             done;
        logic [DVD_W-1:0] quotient;
        logic [DVS_W-1:0] remainder;
    } div_rsp_t;

endpackage

// File: hdl/upcs_div.sv
// ----------------------------------------------------------------------------
// upcs_div
// Restoring radix-2 divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module upcs_div
(
    input  logic               clk,
    input  logic               rst_n,
    input  upcs_pkg::div_cmd_t cmd,
    output upcs_pkg::div_rsp_t rsp
);
    import upcs_pkg::*;

    logic [DVS_W-1:0]      rem_reg, rem_next;
    logic [DVD_W-1:0]      quo_reg, quo_next;
    logic [DVS_W-1:0]      dvs_reg, dvs_next;
    logic [DIV_STEP_W-1:0] step_reg, step_next;
    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;

    logic [DVS_W:0] trial;
    logic           fits;

    always_comb
    begin
        trial = {rem_reg, quo_reg[DVD_W-1]};
        fits  = (trial >= {1'b0, dvs_reg});

        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;

        if (cmd.start)
        begin
            rem_next  = '0;
            quo_next  = cmd.dividend;
            dvs_next  = cmd.divisor;
            step_next = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            // shift in the next dividend bit, subtract when it fits
            rem_next  = fits ? DVS_W'(trial - {1'b0, dvs_reg}) : trial[DVS_W-1:0];
            quo_next  = {quo_reg[DVD_W-2:0], fits};
            step_next = step_reg + 1'b1;
            if (step_reg == DIV_STEP_W'(DVD_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg  <= '0;
            quo_reg  <= '0;
            dvs_reg  <= '0;
            step_reg <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            rem_reg  <= rem_next;
            quo_reg  <= quo_next;
            dvs_reg  <= dvs_next;
            step_reg <= step_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign rsp.done      = done_reg;
    assign rsp.quotient  = quo_reg;
    assign rsp.remainder = rem_reg;

endmodule

// File: hdl/upcs_table.sv
// ----------------------------------------------------------------------------
// upcs_table
// Per-slot hint store with reset-cleared valid bits and a registered read.
// ----------------------------------------------------------------------------
module upcs_table
(
    input  logic               clk,
    input  logic               rst_n,
    input  upcs_pkg::tbl_cmd_t cmd,
    output upcs_pkg::tbl_rsp_t rsp
);
    import upcs_pkg::*;

    logic [SLOTS-1:0] valid_reg;
    hint_t            store_mem [SLOTS];
    logic             rd_valid_reg;
    hint_t            rd_hint_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.wr)
            begin
                valid_reg[cmd.addr] <= 1'b1;
            end
            else if (cmd.clr)
            begin
                valid_reg[cmd.addr] <= 1'b0;
            end
            if (cmd.rd)
            begin
                rd_valid_reg <= valid_reg[cmd.addr];
            end
        end
    end

    // entries hold garbage until written; valid bits gate every use
    always_ff @(posedge clk)
    begin
        if (cmd.wr)
        begin
            store_mem[cmd.addr] <= cmd.data;
        end
        if (cmd.rd)
        begin
            rd_hint_reg <= store_mem[cmd.addr];
        end
    end

    assign rsp.valid = rd_valid_reg;
    assign rsp.hint  = rd_hint_reg;

endmodule

// File: hdl/utility_per_cost_selector.sv
// Set and clear pass from the input beat through DISPATCH and FINISH to the result beat;
//   get adds GET_WAIT. Select first takes cursor mod count on the shared divider (MOD_WAIT),
//   then per position PROBE skips an absent one, LOOK drops an invalid or expired hint,
//   and SCORE runs the divider for an eligible one; FINISH then sends the result beat.
// One item at a time: the 32-step divider sets the pace; a waiting result beat holds
//   the following item in FINISH. Reset (rst_n low, async) clears valid bits.
// ----------------------------------------------------------------------------
// utility_per_cost_selector
// Thread hint table with a best utility-per-cost selector. A small sequencer
// walks the candidate positions in rotation and scores each eligible thread
// on one shared iterative divider.
// ----------------------------------------------------------------------------
`include "utility_per_cost_selector_defines.svh"

module utility_per_cost_selector
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // thread_id[2:0] utility[18:3] deadline[50:19] cost[82:51] flags[90:83]
    // candidate_count[94:91] cursor[102:95] now_tick[134:103]
    // present_mask[142:135], bit 143 zero
    input  logic [upcs_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    // mode[1:0]
    input  logic [1:0]                          s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // chosen[2:0] peak_score[34:3] hint_utility[50:35] hint_deadline[82:51]
    // hint_cost[114:83] hint_flags[122:115], bits 127:123 zero
    output logic [upcs_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
    // status[0]
    output logic [0:0]                          m_axis_tuser
);
    import upcs_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_GET_WAIT,
        ST_MOD_WAIT,
        ST_PROBE,
        ST_LOOK,
        ST_SCORE,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic                status;
        logic [CHOSEN_W-1:0] chosen;
        logic [SCORE_W-1:0]  peak_score;
        hint_t               hint;
    } result_t;

    // ------------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------------
    state_t                state_reg, state_next;
    mode_t                 mode_reg, mode_next;
    logic [TID_W-1:0]      tid_reg, tid_next;
    hint_t                 item_reg, item_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic [CURSOR_W-1:0]   cursor_reg, cursor_next;
    logic [TICK_W-1:0]     now_reg, now_next;
    logic [MASK_W-1:0]     mask_reg, mask_next;
    logic [CNT_W-1:0]      idx_reg, idx_next;
    logic [CNT_W-1:0]      off_reg, off_next;
    logic                  found_reg, found_next;
    logic [CNT_W-1:0]      best_idx_reg, best_idx_next;
    logic [SCORE_W-1:0]    best_reg, best_next;
    result_t               res_reg, res_next;
    result_t               out_reg, out_next;
    logic                  out_valid_reg, out_valid_next;

    // ------------------------------------------------------------------------
    // Shared units
    // ------------------------------------------------------------------------
    tbl_cmd_t tbl_cmd;
    tbl_rsp_t tbl_rsp;
    div_cmd_t div_cmd;
    div_rsp_t div_rsp;

    upcs_table u_table
    (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (tbl_cmd),
        .rsp   (tbl_rsp)
    );

    upcs_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (div_cmd),
        .rsp   (div_rsp)
    );

    // ------------------------------------------------------------------------
    // Per-position helpers
    // ------------------------------------------------------------------------
    logic               tid_ok;
    logic               pos_ok;
    logic [CNT_W-1:0]   idx_inc;
    logic [TICK_W-1:0]  slack;
    logic               eligible;
    logic [SCORE_W-1:0] score;
    logic               accept;

    assign accept = s_axis_tvalid && s_axis_tready;
    assign tid_ok = (int'(tid_reg) < SLOTS);

    // a position past the table or past the mask counts as absent
    assign pos_ok = (int'(idx_reg) < SLOTS) && (int'(idx_reg) < MASK_W)
                    && mask_reg[idx_reg[MASK_IDX_W-1:0]];

    // step to the next position in rotation
    assign idx_inc = ((idx_reg + 1'b1) == cnt_reg) ? '0 : (idx_reg + 1'b1);

    // deadline still ahead when the wrapped difference is non-negative
    assign slack    = tbl_rsp.hint.deadline - now_reg;
    assign eligible = !tbl_rsp.hint.flags[FLAG_DEADLINE_BIT] || !slack[TICK_W-1];

    // a 16-bit utility shifted by 16 always fits the score width
    assign score = div_rsp.quotient;

    // ------------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------------
    always_comb
    begin
        state_next     = state_reg;
        mode_next      = mode_reg;
        tid_next       = tid_reg;
        item_next      = item_reg;
        cnt_next       = cnt_reg;
        cursor_next    = cursor_reg;
        now_next       = now_reg;
        mask_next      = mask_reg;
        idx_next       = idx_reg;
        off_next       = off_reg;
        found_next     = found_reg;
        best_idx_next  = best_idx_reg;
        best_next      = best_reg;
        res_next       = res_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;

        tbl_cmd      = '0;
        tbl_cmd.data = item_reg;
        div_cmd      = '0;

        // drop the result beat once taken
        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    mode_next             = mode_t'(s_axis_tuser);
                    tid_next              = s_axis_tdata[2:0];
                    item_next.utility     = s_axis_tdata[18:3];
                    item_next.deadline    = s_axis_tdata[50:19];
                    item_next.cost        = s_axis_tdata[82:51];
                    item_next.flags       = s_axis_tdata[90:83];
                    cnt_next              = s_axis_tdata[94:91];
                    cursor_next           = s_axis_tdata[102:95];
                    now_next              = s_axis_tdata[134:103];
                    mask_next             = s_axis_tdata[142:135];
                    state_next            = ST_DISPATCH;
                end
            end

            ST_DISPATCH:
            begin
                res_next   = '0;
                state_next = ST_FINISH;
                case (mode_reg)
                    MODE_SET:
                    begin
                        if (!tid_ok || (item_reg.cost == '0))
                        begin
                            res_next.status = 1'b1;
                        end
                        else
                        begin
                            tbl_cmd.wr   = 1'b1;
                            tbl_cmd.addr = SLOT_W'(tid_reg);
                        end
                    end
                    MODE_CLEAR:
                    begin
                        tbl_cmd.clr  = tid_ok;
                        tbl_cmd.addr = SLOT_W'(tid_reg);
                    end
                    MODE_GET:
                    begin
                        if (!tid_ok)
                        begin
                            res_next.status = 1'b1;
                        end
                        else
                        begin
                            tbl_cmd.rd   = 1'b1;
                            tbl_cmd.addr = SLOT_W'(tid_reg);
                            state_next   = ST_GET_WAIT;
                        end
                    end
                    MODE_SELECT:
                    begin
                        if (cnt_reg == '0)
                        begin
                            res_next.status = 1'b1;
                        end
                        else
                        begin
                            // rotation start: cursor mod count on the divider
                            div_cmd.start    = 1'b1;
                            div_cmd.dividend = DVD_W'(cursor_reg);
                            div_cmd.divisor  = DVS_W'(cnt_reg);
                            state_next       = ST_MOD_WAIT;
                        end
                    end
                    default:
                    begin
                        res_next.status = 1'b1;
                    end
                endcase
            end

            ST_GET_WAIT:
            begin
                if (tbl_rsp.valid)
                begin
                    res_next.hint = tbl_rsp.hint;
                end
                else
                begin
                    res_next.status = 1'b1;
                end
                state_next = ST_FINISH;
            end

            ST_MOD_WAIT:
            begin
                if (div_rsp.done)
                begin
                    idx_next      = div_rsp.remainder[CNT_W-1:0];
                    off_next      = '0;
                    found_next    = 1'b0;
                    best_idx_next = '0;
                    best_next     = '0;
                    state_next    = ST_PROBE;
                end
            end

            ST_PROBE:
            begin
                if (off_reg == cnt_reg)
                begin
                    res_next.status     = !found_reg;
                    res_next.chosen     = CHOSEN_W'(best_idx_reg);
                    res_next.peak_score = best_reg;
                    state_next          = ST_FINISH;
                end
                else if (pos_ok)
                begin
                    tbl_cmd.rd   = 1'b1;
                    tbl_cmd.addr = SLOT_W'(idx_reg);
                    state_next   = ST_LOOK;
                end
                else
                begin
                    idx_next = idx_inc;
                    off_next = off_reg + 1'b1;
                end
            end

            ST_LOOK:
            begin
                if (tbl_rsp.valid && eligible)
                begin
                    div_cmd.start    = 1'b1;
                    div_cmd.dividend = {tbl_rsp.hint.utility, {SCORE_SHIFT{1'b0}}};
                    div_cmd.divisor  = tbl_rsp.hint.cost;
                    state_next       = ST_SCORE;
                end
                else
                begin
                    idx_next   = idx_inc;
                    off_next   = off_reg + 1'b1;
                    state_next = ST_PROBE;
                end
            end

            ST_SCORE:
            begin
                if (div_rsp.done)
                begin
                    // strict compare keeps the earliest position on a tie
                    if (!found_reg || (score > best_reg))
                    begin
                        found_next    = 1'b1;
                        best_idx_next = idx_reg;
                        best_next     = score;
                    end
                    idx_next   = idx_inc;
                    off_next   = off_reg + 1'b1;
                    state_next = ST_PROBE;
                end
            end

            ST_FINISH:
            begin
                // hold until the output register is free
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_next       = res_reg;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            mode_reg      <= MODE_SET;
            tid_reg       <= '0;
            item_reg      <= '0;
            cnt_reg       <= '0;
            cursor_reg    <= '0;
            now_reg       <= '0;
            mask_reg      <= '0;
            idx_reg       <= '0;
            off_reg       <= '0;
            found_reg     <= 1'b0;
            best_idx_reg  <= '0;
            best_reg      <= '0;
            res_reg       <= '0;
            out_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            mode_reg      <= mode_next;
            tid_reg       <= tid_next;
            item_reg      <= item_next;
            cnt_reg       <= cnt_next;
            cursor_reg    <= cursor_next;
            now_reg       <= now_next;
            mask_reg      <= mask_next;
            idx_reg       <= idx_next;
            off_reg       <= off_next;
            found_reg     <= found_next;
            best_idx_reg  <= best_idx_next;
            best_reg      <= best_next;
            res_reg       <= res_next;
            out_reg       <= out_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // ------------------------------------------------------------------------
    // Ports
    // ------------------------------------------------------------------------
    assign s_axis_tready   = (state_reg == ST_IDLE);
    assign m_axis_tvalid   = out_valid_reg;
    assign m_axis_tuser[0] = out_reg.status;
    assign m_axis_tdata    = {5'd0,
                              out_reg.hint.flags,
                              out_reg.hint.cost,
                              out_reg.hint.deadline,
                              out_reg.hint.utility,
                              out_reg.peak_score,
                              out_reg.chosen};

    // ------------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------------
    `UPCS_ASSERT_IMP(a_result_from_finish, $rose(m_axis_tvalid), $past(state_reg == ST_FINISH))
    `UPCS_ASSERT_IMP(a_div_done_awaited, div_rsp.done, (state_reg == ST_MOD_WAIT) || (state_reg == ST_SCORE))
    `UPCS_ASSERT_IMP(a_probe_in_bounds, state_reg == ST_PROBE, off_reg <= cnt_reg)
    `UPCS_ASSERT_NXT(a_accept_dispatches, accept, state_reg == ST_DISPATCH)

endmodule
